/* rtl/core/mbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and delimiter/terminator tables for the mbox splitter.
// No dependencies; used by mbs_ctrl, mbs_datapath and mbox_message_splitter.
package mbs_pkg;

  localparam logic [7:0] LF = 8'h0a;
  localparam logic [7:0] CR = 8'h0d;

  localparam logic [3:0] STD_LEN = 4'd6;
  localparam logic [3:0] ALT_LEN = 4'd15;

  localparam logic [3:0] TERM_LAST_IDX = 4'd4;

  localparam logic MODE_STD = 1'b0;
  localparam logic MODE_ALT = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_EOF   = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    SEG_IDLE  = 4'b0001,
    SEG_FLUSH = 4'b0010,
    SEG_CUR   = 4'b0100,
    SEG_TERM  = 4'b1000
  } seg_t;

  typedef struct packed {
    logic accept;
    logic load_out;
    logic last;
    seg_t seg;
  } dp_cmd_t;

  typedef struct packed {
    logic dec_flush;
    logic dec_cur;
    logic dec_term;
    logic plan_cur;
    logic plan_term;
    logic seg_end;
    logic out_free;
  } dp_status_t;

  function automatic logic [3:0] delim_len(input logic mode);
    return (mode == MODE_ALT) ? ALT_LEN : STD_LEN;
  endfunction

  function automatic logic [7:0] delim_at(input logic mode, input logic [3:0] idx);
    logic [7:0] b;
    if (mode == MODE_ALT) begin
      if (idx == 4'd0) b = LF;
      else if (idx <= 4'd7) b = 8'h10;
      else if (idx <= 4'd13) b = 8'h11;
      else b = 8'h53;
    end else begin
      unique case (idx)
        4'd0:    b = LF;
        4'd1:    b = 8'h46;
        4'd2:    b = 8'h72;
        4'd3:    b = 8'h6f;
        4'd4:    b = 8'h6d;
        default: b = 8'h20;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] term_at(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CR;
      3'd1:    b = LF;
      3'd2:    b = 8'h2e;
      3'd3:    b = CR;
      default: b = LF;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/mbs_ctrl.sv */
`timescale 1ns / 1ps
// Output sequencer FSM: walks flush, current-byte and terminator segments.
// Depends on mbs_pkg; drives mbs_datapath through dp_cmd_t.
module mbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mbs_pkg::dp_status_t status,
  output mbs_pkg::dp_cmd_t    cmd
);
  import mbs_pkg::*;

  seg_t state, state_next;
  seg_t first_seg, after_seg;
  logic load_out, item_done, accept;

  always_comb begin
    unique case (state)
      SEG_FLUSH: after_seg = status.plan_cur ? SEG_CUR :
                             (status.plan_term ? SEG_TERM : SEG_IDLE);
      SEG_CUR:   after_seg = status.plan_term ? SEG_TERM : SEG_IDLE;
      default:   after_seg = SEG_IDLE;
    endcase
  end

  always_comb begin
    priority if (status.dec_flush) first_seg = SEG_FLUSH;
    else if (status.dec_cur)       first_seg = SEG_CUR;
    else if (status.dec_term)      first_seg = SEG_TERM;
    else                           first_seg = SEG_IDLE;
  end

  assign load_out  = (state != SEG_IDLE) && status.out_free;
  assign item_done = load_out && status.seg_end && (after_seg == SEG_IDLE);
  assign s_tready  = (state == SEG_IDLE) || item_done;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    priority if (accept)                  state_next = first_seg;
    else if (load_out && status.seg_end)  state_next = after_seg;
    else                                  state_next = state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.accept   = accept;
  assign cmd.load_out = load_out;
  assign cmd.last     = item_done;
  assign cmd.seg      = state;

  a_idle_no_load: assert property (@(posedge clk) disable iff (rst)
    (state == SEG_IDLE) |-> !cmd.load_out)
    else $error("output load while idle");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (item_done && !accept) |=> (state == SEG_IDLE))
    else $error("sequencer did not return to idle");

  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    (accept && state != SEG_IDLE) |-> item_done)
    else $error("item accepted while results pending");

endmodule

/* rtl/core/mbs_datapath.sv */
`timescale 1ns / 1ps
// Matcher state, per-item plan decode, byte generation and output register.
// Depends on mbs_pkg; controlled by mbs_ctrl.
module mbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_mode,
  output logic                format_mode,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_byte,
  input  mbs_pkg::dp_cmd_t    cmd,
  output mbs_pkg::dp_status_t status,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  import mbs_pkg::*;

  logic [3:0] match_pos, match_pos_next;
  logic       skipping, skipping_next;
  logic       nonempty, nonempty_next;
  logic       done, done_next;

  logic [3:0] flush_cnt, dec_flush_cnt;
  logic [7:0] cur_byte;
  logic       plan_cur, plan_term;
  logic       dec_cur, dec_term;

  logic [3:0] idx;
  logic       cr_sent;

  logic [7:0] cur_delim, unit_byte, out_byte;
  logic [3:0] mp_inc;
  logic       expand, unit_done, seg_end;

  assign cur_delim = delim_at(format_mode, match_pos);
  assign mp_inc    = match_pos + 4'd1;

  always_comb begin
    dec_flush_cnt  = 4'd0;
    dec_cur        = 1'b0;
    dec_term       = 1'b0;
    match_pos_next = match_pos;
    skipping_next  = skipping;
    nonempty_next  = nonempty;
    done_next      = done;
    unique case (in_cmd)
      CMD_START: begin
        match_pos_next = 4'd1;
        skipping_next  = 1'b0;
        nonempty_next  = 1'b0;
        done_next      = 1'b0;
      end
      CMD_DATA: begin
        if (done) begin
          done_next = done;
        end else if (skipping) begin
          if (in_byte == LF) skipping_next = 1'b0;
        end else if (match_pos != 4'd0 && in_byte != cur_delim) begin
          dec_flush_cnt = match_pos;
          nonempty_next = 1'b1;
          if (in_byte == LF) begin
            match_pos_next = 4'd1;
          end else begin
            dec_cur        = 1'b1;
            match_pos_next = 4'd0;
          end
        end else if (in_byte == cur_delim) begin
          if (mp_inc >= delim_len(format_mode)) begin
            dec_term       = nonempty;
            nonempty_next  = 1'b0;
            match_pos_next = 4'd0;
            skipping_next  = 1'b1;
          end else begin
            match_pos_next = mp_inc;
          end
        end else begin
          dec_cur       = 1'b1;
          nonempty_next = 1'b1;
        end
      end
      CMD_EOF: begin
        if (!done) begin
          if (!skipping) dec_flush_cnt = match_pos;
          dec_term       = nonempty || (!skipping && match_pos != 4'd0);
          nonempty_next  = 1'b0;
          skipping_next  = 1'b0;
          match_pos_next = 4'd0;
          done_next      = 1'b1;
        end
      end
      default: begin
        done_next = done;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.seg)
      SEG_FLUSH: unit_byte = delim_at(format_mode, idx);
      SEG_CUR:   unit_byte = cur_byte;
      default:   unit_byte = term_at(idx[2:0]);
    endcase
    expand    = (cmd.seg != SEG_TERM) && (format_mode == MODE_STD) &&
                (unit_byte == LF) && !cr_sent;
    out_byte  = expand ? CR : unit_byte;
    unit_done = !expand;
    unique case (cmd.seg)
      SEG_FLUSH: seg_end = unit_done && (idx == flush_cnt - 4'd1);
      SEG_CUR:   seg_end = unit_done;
      SEG_TERM:  seg_end = (idx == TERM_LAST_IDX);
      default:   seg_end = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_STD;
      match_pos   <= 4'd1;
      skipping    <= 1'b0;
      nonempty    <= 1'b0;
      done        <= 1'b0;
      flush_cnt   <= 4'd0;
      plan_cur    <= 1'b0;
      plan_term   <= 1'b0;
      idx         <= 4'd0;
      cr_sent     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        format_mode <= cfg_mode;
        if (match_pos >= delim_len(cfg_mode)) match_pos <= delim_len(cfg_mode) - 4'd1;
      end else if (cmd.accept) begin
        match_pos <= match_pos_next;
        skipping  <= skipping_next;
        nonempty  <= nonempty_next;
        done      <= done_next;
        flush_cnt <= dec_flush_cnt;
        plan_cur  <= dec_cur;
        plan_term <= dec_term;
      end
      if (cmd.load_out) begin
        cr_sent <= expand;
        if (seg_end) idx <= 4'd0;
        else if (unit_done) idx <= idx + 4'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) cur_byte <= in_byte;
    if (cmd.load_out) begin
      m_tdata <= out_byte;
      m_tlast <= (cmd.seg == SEG_TERM) && (idx == TERM_LAST_IDX);
      m_tuser <= cmd.last;
    end
  end

  assign status.dec_flush = (dec_flush_cnt != 4'd0);
  assign status.dec_cur   = dec_cur;
  assign status.dec_term  = dec_term;
  assign status.plan_cur  = plan_cur;
  assign status.plan_term = plan_term;
  assign status.seg_end   = seg_end;
  assign status.out_free  = !m_tvalid || m_tready;

  a_mp_in_range: assert property (@(posedge clk) disable iff (rst)
    match_pos < delim_len(format_mode))
    else $error("match position beyond delimiter");

  a_skip_clear: assert property (@(posedge clk) disable iff (rst)
    (skipping || done) |-> (match_pos == 4'd0))
    else $error("partial match held while skipping or done");

  a_cr_std_only: assert property (@(posedge clk) disable iff (rst)
    cr_sent |-> (format_mode == MODE_STD))
    else $error("CR expansion in alternate mode");

  a_end_on_lf: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == LF && m_tuser))
    else $error("message end not on final terminator LF");

endmodule

/* rtl/core/mbox_message_splitter.sv */
`timescale 1ns / 1ps
// Top level of the mbox message splitter: stream ports, APB register, FSM and datapath.
// Depends on mbs_pkg, mbs_ctrl and mbs_datapath.
//
// Takes one transaction per cycle, while m_tready does not stall the output, when it
// yields at most one output byte (an ordinary message byte, a matched delimiter byte,
// a skipped byte). A transaction that yields more bytes (at most 19: a 14-byte partial
// delimiter flush plus the 5-byte terminator at end of file) holds the input, since
// results leave through a single output register loaded one byte per cycle unless
// stalled; the next transaction is taken in the cycle its last byte loads. format_mode
// sits at address 0; the user must write it only while the block is idle (unenforced).
module mbox_message_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // message_end
  output logic        m_tuser,   // [0] run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       format_mode;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, format_mode} : 32'd0;

  mbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_mode    (pwdata[0]),
    .format_mode (format_mode),
    .in_cmd      (s_tuser),
    .in_byte     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule
